// ===== sv/lrsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsp_pkg
// Shared types and constants of the linear ramp slot pool.
// ----------------------------------------------------------------------------
package lrsp_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_OUT     = 16;
  localparam int OUT_CNT_W   = 5;
  localparam int SLOT_FLD_W  = 6;
  localparam int TGT_W       = 16;
  localparam int VAL_W       = 32;
  localparam int DUR_W       = 20;
  localparam int TIME_W      = 32;
  localparam int BEGIN_W     = 33;
  localparam int DIFF_W      = 33;
  localparam int PROD_W      = 53;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ADD  = 1'b1;
  localparam logic RES_ADD   = 1'b0;
  localparam logic RES_WRITE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic cap_in;
    logic time_inc;
    logic idx_clr;
    logic idx_inc;
    logic scan_ev;
    logic add_wr;
    logic out_add;
    logic fin;
    logic mul;
    logic div_start;
    logic res_ramp;
    logic pend_push;
    logic pend_load;
    logic pend_flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_idx;
    logic cls_skip;
    logic cls_fin;
    logic div_busy;
    logic out_free;
    logic pend_v;
  } sts_t;

endpackage

// ===== sv/linear_ramp_slot_pool_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_ramp_slot_pool_unit
// Pool of linear ramp generators stepped by a millisecond tick.
// ----------------------------------------------------------------------------
// add item: scans every slot for a duplicate target and a free slot, then writes and reports
// tick item: steps time and walks the slots; idle slots are skipped, finishing slots
//   take their goal value, ramping slots pass a multiply and the 53-step serial divider
// one item at a time; results leave through an output register, which out_ready can stall
// reset: synchronous active low, clears time, slot activity and control state
module linear_ramp_slot_pool_unit #(
  parameter int SLOTS = lrsp_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [lrsp_pkg::TGT_W-1:0]         in_target_id,
  input  logic signed [lrsp_pkg::VAL_W-1:0]  in_start_value,
  input  logic signed [lrsp_pkg::VAL_W-1:0]  in_end_value,
  input  logic [lrsp_pkg::DUR_W-1:0]         in_duration,
  input  logic [lrsp_pkg::DUR_W-1:0]         in_start_delay,
  input  logic                               in_skip_duplicate_check,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_result_kind,
  output logic                               out_accepted,
  output logic [lrsp_pkg::SLOT_FLD_W-1:0]    out_slot,
  output logic [lrsp_pkg::TGT_W-1:0]         out_write_target,
  output logic signed [lrsp_pkg::VAL_W-1:0]  out_write_value,
  output logic                               out_ramp_done,
  output logic                               out_last
);
  lrsp_pkg::cmd_t cmd;
  lrsp_pkg::sts_t sts;

  lrsp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_kind (in_kind),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lrsp_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_target_id           (in_target_id),
    .in_start_value         (in_start_value),
    .in_end_value           (in_end_value),
    .in_duration            (in_duration),
    .in_start_delay         (in_start_delay),
    .in_skip_duplicate_check(in_skip_duplicate_check),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_result_kind        (out_result_kind),
    .out_accepted           (out_accepted),
    .out_slot               (out_slot),
    .out_write_target       (out_write_target),
    .out_write_value        (out_write_value),
    .out_ramp_done          (out_ramp_done),
    .out_last               (out_last)
  );

endmodule

// ===== sv/lrsp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrsp_div #(
  parameter int NUM_W = lrsp_pkg::PROD_W,
  parameter int DEN_W = lrsp_pkg::DUR_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, q_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

// ===== sv/lrsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsp_dp
// Slot memory, time counter, ramp arithmetic and result registers.
// ----------------------------------------------------------------------------
module lrsp_dp #(
  parameter int SLOTS = lrsp_pkg::SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lrsp_pkg::cmd_t                       cmd,
  output lrsp_pkg::sts_t                       sts,
  input  logic [lrsp_pkg::TGT_W-1:0]           in_target_id,
  input  logic signed [lrsp_pkg::VAL_W-1:0]    in_start_value,
  input  logic signed [lrsp_pkg::VAL_W-1:0]    in_end_value,
  input  logic [lrsp_pkg::DUR_W-1:0]           in_duration,
  input  logic [lrsp_pkg::DUR_W-1:0]           in_start_delay,
  input  logic                                 in_skip_duplicate_check,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_result_kind,
  output logic                                 out_accepted,
  output logic [lrsp_pkg::SLOT_FLD_W-1:0]      out_slot,
  output logic [lrsp_pkg::TGT_W-1:0]           out_write_target,
  output logic signed [lrsp_pkg::VAL_W-1:0]    out_write_value,
  output logic                                 out_ramp_done,
  output logic                                 out_last
);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TGT_W = lrsp_pkg::TGT_W;
  localparam int VAL_W = lrsp_pkg::VAL_W;
  localparam int DUR_W = lrsp_pkg::DUR_W;
  localparam int BEG_W = lrsp_pkg::BEGIN_W;

  typedef struct packed {
    logic [TGT_W-1:0] tgt;
    logic [VAL_W-1:0] origin;
    logic [VAL_W-1:0] goal;
    logic [BEG_W-1:0] begin_t;
    logic [DUR_W-1:0] len;
  } ent_t;

  ent_t                        slot_mem [SLOTS];
  ent_t                        rd_r;
  ent_t                        wr_ent;
  logic [SLOTS-1:0]            active_r;
  logic [lrsp_pkg::TIME_W-1:0] time_r;
  logic [IDX_W-1:0]            idx_r;

  logic [TGT_W-1:0]            tgt_in_r;
  logic [VAL_W-1:0]            start_in_r;
  logic [VAL_W-1:0]            end_in_r;
  logic [DUR_W-1:0]            dur_in_r;
  logic [DUR_W-1:0]            delay_in_r;
  logic                        skip_in_r;

  logic                        dup_r;
  logic                        found_r;
  logic [IDX_W-1:0]            free_r;
  logic                        add_ok;

  logic [BEG_W-1:0]            now33;
  logic [BEG_W:0]              end34;
  logic [lrsp_pkg::DIFF_W-1:0] diff;
  logic [lrsp_pkg::DIFF_W-1:0] mag;
  logic [BEG_W-1:0]            elapsed;
  logic [lrsp_pkg::PROD_W-1:0] prod_r;
  logic                        neg_r;
  logic                        div_busy;
  logic [lrsp_pkg::PROD_W-1:0] quo;
  logic [lrsp_pkg::DIFF_W:0]   q_sgn;

  logic [VAL_W-1:0]            res_val_r;
  logic                        res_done_r;

  logic                        pend_v_r;
  logic [IDX_W-1:0]            pend_slot_r;
  logic [TGT_W-1:0]            pend_tgt_r;
  logic [VAL_W-1:0]            pend_val_r;
  logic                        pend_done_r;

  logic                        out_valid_r;
  logic                        out_kind_r;
  logic                        out_acc_r;
  logic [IDX_W-1:0]            out_slot_r;
  logic [TGT_W-1:0]            out_tgt_r;
  logic [VAL_W-1:0]            out_val_r;
  logic                        out_done_r;
  logic                        out_last_r;
  logic                        out_free;

  assign add_ok   = found_r && (skip_in_r || !dup_r);
  assign out_free = !out_valid_r || out_ready;

  assign now33   = {1'b0, time_r};
  assign end34   = {1'b0, rd_r.begin_t} + {{(BEG_W + 1 - DUR_W){1'b0}}, rd_r.len};
  assign diff    = {rd_r.goal[VAL_W-1], rd_r.goal} - {rd_r.origin[VAL_W-1], rd_r.origin};
  assign mag     = diff[lrsp_pkg::DIFF_W-1] ? -diff : diff;
  assign elapsed = now33 - rd_r.begin_t;
  assign q_sgn   = neg_r ? -{1'b0, quo[lrsp_pkg::DIFF_W-1:0]}
                         : {1'b0, quo[lrsp_pkg::DIFF_W-1:0]};

  assign wr_ent.tgt     = tgt_in_r;
  assign wr_ent.origin  = start_in_r;
  assign wr_ent.goal    = end_in_r;
  assign wr_ent.begin_t = now33 + {{(BEG_W - DUR_W){1'b0}}, delay_in_r};
  assign wr_ent.len     = dur_in_r;

  lrsp_div #(
    .NUM_W(lrsp_pkg::PROD_W),
    .DEN_W(DUR_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (prod_r),
    .den  (rd_r.len),
    .busy (div_busy),
    .quo  (quo)
  );

  // slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.add_wr && add_ok) begin
      slot_mem[free_r] <= wr_ent;
    end
    rd_r <= slot_mem[idx_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.time_inc) begin
        time_r <= time_r + 1'b1;
      end
      if (cmd.add_wr && add_ok) begin
        active_r[free_r] <= 1'b1;
      end
      if (cmd.fin) begin
        active_r[idx_r] <= 1'b0;
      end
      if (cmd.pend_load) begin
        pend_v_r <= 1'b1;
      end else if (cmd.pend_flush) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.out_add || cmd.pend_push || cmd.pend_flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      tgt_in_r   <= in_target_id;
      start_in_r <= in_start_value;
      end_in_r   <= in_end_value;
      dur_in_r   <= in_duration;
      delay_in_r <= in_start_delay;
      skip_in_r  <= in_skip_duplicate_check;
      dup_r      <= 1'b0;
      found_r    <= 1'b0;
      free_r     <= '0;
    end else if (cmd.scan_ev) begin
      if (active_r[idx_r] && rd_r.tgt == tgt_in_r) begin
        dup_r <= 1'b1;
      end
      if (!active_r[idx_r] && !found_r) begin
        found_r <= 1'b1;
        free_r  <= idx_r;
      end
    end

    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end

    if (cmd.mul) begin
      prod_r <= lrsp_pkg::PROD_W'(mag) * lrsp_pkg::PROD_W'(elapsed[DUR_W-1:0]);
      neg_r  <= diff[lrsp_pkg::DIFF_W-1];
    end

    if (cmd.fin) begin
      res_val_r  <= rd_r.goal;
      res_done_r <= 1'b1;
    end else if (cmd.res_ramp) begin
      res_val_r  <= rd_r.origin + q_sgn[VAL_W-1:0];
      res_done_r <= 1'b0;
    end

    if (cmd.pend_load) begin
      pend_slot_r <= idx_r;
      pend_tgt_r  <= rd_r.tgt;
      pend_val_r  <= res_val_r;
      pend_done_r <= res_done_r;
    end

    if (cmd.out_add) begin
      out_kind_r <= lrsp_pkg::RES_ADD;
      out_acc_r  <= add_ok;
      out_slot_r <= add_ok ? free_r : '0;
      out_tgt_r  <= '0;
      out_val_r  <= '0;
      out_done_r <= 1'b0;
      out_last_r <= 1'b1;
    end else if (cmd.pend_push || cmd.pend_flush) begin
      out_kind_r <= lrsp_pkg::RES_WRITE;
      out_acc_r  <= 1'b0;
      out_slot_r <= pend_slot_r;
      out_tgt_r  <= pend_tgt_r;
      out_val_r  <= pend_val_r;
      out_done_r <= pend_done_r;
      out_last_r <= cmd.pend_flush;
    end
  end

  assign sts.last_idx = idx_r == IDX_W'(SLOTS - 1);
  assign sts.cls_skip = !active_r[idx_r] || now33 < rd_r.begin_t;
  assign sts.cls_fin  = {1'b0, now33} >= end34;
  assign sts.div_busy = div_busy;
  assign sts.out_free = out_free;
  assign sts.pend_v   = pend_v_r;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_accepted     = out_acc_r;
  assign out_slot         = lrsp_pkg::SLOT_FLD_W'(out_slot_r);
  assign out_write_target = out_tgt_r;
  assign out_write_value  = out_val_r;
  assign out_ramp_done    = out_done_r;
  assign out_last         = out_last_r;

endmodule

// ===== sv/lrsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsp_ctrl
// Sequencer for add scans and tick walks over the slot pool.
// ----------------------------------------------------------------------------
module lrsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_ready,
  input  lrsp_pkg::sts_t sts,
  output lrsp_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_EV, S_A_RESP,
    S_T_RD, S_T_EV, S_T_DST, S_T_DIV, S_T_RES, S_T_EMIT, S_T_FLUSH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [lrsp_pkg::OUT_CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in  = 1'b1;
          cmd.idx_clr = 1'b1;
          cnt_nxt     = '0;
          if (in_kind == lrsp_pkg::KIND_ADD) begin
            state_nxt = S_A_RD;
          end else begin
            cmd.time_inc = 1'b1;
            state_nxt    = S_T_RD;
          end
        end
      end
      S_A_RD: state_nxt = S_A_EV;
      S_A_EV: begin
        cmd.scan_ev = 1'b1;
        if (sts.last_idx) begin
          state_nxt = S_A_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_A_RD;
        end
      end
      S_A_RESP: begin
        if (sts.out_free) begin
          cmd.add_wr  = 1'b1;
          cmd.out_add = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_T_RD: state_nxt = S_T_EV;
      S_T_EV: begin
        if (sts.cls_skip) begin
          if (sts.last_idx) begin
            state_nxt = S_T_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_T_RD;
          end
        end else if (sts.cls_fin) begin
          cmd.fin   = 1'b1;
          state_nxt = S_T_EMIT;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_T_DST;
        end
      end
      S_T_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_T_DIV;
      end
      S_T_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_T_RES;
        end
      end
      S_T_RES: begin
        cmd.res_ramp = 1'b1;
        state_nxt    = S_T_EMIT;
      end
      S_T_EMIT: begin
        // beyond the result cap the write still happens but is not reported
        if (cnt_r != lrsp_pkg::OUT_CNT_W'(lrsp_pkg::MAX_OUT) &&
            sts.pend_v && !sts.out_free) begin
          state_nxt = S_T_EMIT;
        end else begin
          if (cnt_r != lrsp_pkg::OUT_CNT_W'(lrsp_pkg::MAX_OUT)) begin
            cmd.pend_push = sts.pend_v;
            cmd.pend_load = 1'b1;
            cnt_nxt       = cnt_r + 1'b1;
          end
          if (sts.last_idx) begin
            state_nxt = S_T_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_T_RD;
          end
        end
      end
      S_T_FLUSH: begin
        if (!sts.pend_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.pend_flush = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
